/* src/bffa_pkg.sv */
// ----------------------------------------------------------------------------
// bffa_pkg
// shared constants, types and helpers of the best-fit free-list allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int PoolAddrBits  = 16;
  localparam int MaxFreeSegs   = 64;
  localparam int AlignBytes    = 8;
  localparam int HeaderBytes   = 8;
  localparam int LinkBytes     = 16;
  localparam int PoolHeadBytes = 16;

  localparam int HdrSize    = ((HeaderBytes + AlignBytes - 1) / AlignBytes) * AlignBytes;
  localparam int FirstStart = ((PoolHeadBytes + AlignBytes - 1) / AlignBytes) * AlignBytes;
  localparam int AddrSpan   = 1 << PoolAddrBits;
  localparam int PoolLimit  = (AddrSpan < 65536) ? AddrSpan : 65536;
  localparam int TagDepth   = (AddrSpan + AlignBytes - 1) / AlignBytes;
  localparam int TagBits    = (TagDepth > 1) ? $clog2(TagDepth) : 1;
  localparam int AlignShift = $clog2(AlignBytes);
  localparam int SegIdxBits = $clog2(MaxFreeSegs);
  localparam int SegCntBits = $clog2(MaxFreeSegs + 1);

  localparam logic [16:0] Sat17    = 17'h1FFFF;
  localparam logic [16:0] PoolMin  = 17'd64;
  localparam logic [16:0] PoolMax  = 17'(PoolLimit);
  localparam logic [16:0] NeedMin  = 17'(FirstStart + LinkBytes);
  localparam logic [16:0] FirstSt  = 17'(FirstStart);
  localparam logic [16:0] HdrSz    = 17'(HdrSize);
  localparam logic [17:0] LinkSz   = 18'(LinkBytes);
  localparam logic [17:0] AlignMsk = 18'(AlignBytes - 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_TOTAL  = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REBUILD, S_TAGRD, S_SCAN, S_DECIDE, S_SHIFT_DN, S_SHIFT_UP,
    S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic        we;
    logic [SegIdxBits-1:0] waddr;
    logic [15:0] wstart;
    logic [16:0] wlen;
  } seg_wr_t;

  function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? Sat17 : s[16:0];
  endfunction

endpackage

/* src/bffa_seg_table.sv */
// ----------------------------------------------------------------------------
// bffa_seg_table
// segment table memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module bffa_seg_table
  import bffa_pkg::*;
(
  input  logic                  clk,
  input  seg_wr_t               wr,
  input  logic [SegIdxBits-1:0] raddr,
  output logic [15:0]           rstart,
  output logic [16:0]           rlen
);

  logic [32:0] mem [MaxFreeSegs];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= {wr.wstart, wr.wlen};
    end
    {rstart, rlen} <= mem[raddr];
  end

endmodule

/* src/bffa_tag_store.sv */
// ----------------------------------------------------------------------------
// bffa_tag_store
// block size tags, one entry per aligned pool slot
// ----------------------------------------------------------------------------
module bffa_tag_store
  import bffa_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [TagBits-1:0] waddr,
  input  logic [16:0]        wdata,
  input  logic [TagBits-1:0] raddr,
  output logic [16:0]        rdata
);

  logic [16:0] mem [TagDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/best_fit_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator
// best-fit allocator over an address-ordered free segment table
// ----------------------------------------------------------------------------
// s_axis carries allocate / free items: tdata = {payload_offset, request_bytes,
// mode}. m_axis returns one item per input: status, block_offset,
// freed_bytes and avail_bytes. s_axis_tready is high only while idle.
// An item scans the segment table one entry per cycle through a single
// read port with a shared compare unit, then may shift entries one per
// cycle to remove or insert a segment. The result waits in the output
// register until taken; no new item is accepted meanwhile. Reset and a
// pool_bytes write reload pool size and rebuild the table. Tags of blocks
// never allocated read as undefined. Writing pool_bytes is allowed only
// while idle.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator
  import bffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode, request_bytes, payload_offset, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // status, block_offset, freed_bytes, avail_bytes, pad
);

  state_t state, state_next;

  logic [16:0] pool, free_total;
  logic [SegCntBits-1:0] seg_count;
  logic        mode;
  logic [15:0] poff;
  logic [16:0] real_sz, cur;
  logic [SegIdxBits:0] idx;       // scan pointer
  logic        rd_ok;             // read data valid for entry idx-1
  logic        found, exact;
  logic [SegIdxBits-1:0] pick;
  logic [16:0] best;
  logic [15:0] pick_start;
  logic [16:0] pick_len;
  logic [SegIdxBits:0] pos;
  logic        pos_done;
  logic [15:0] prev_start, nxt_start;
  logic [16:0] prev_len, nxt_len;
  logic        has_prev, has_nxt;
  logic [16:0] size;
  logic [SegIdxBits:0] sh;
  logic [15:0] sh_start;
  logic [16:0] sh_len;
  logic        sh_have;
  logic [2:0]  status;
  logic [15:0] blk_off;
  logic [16:0] freed;

  seg_wr_t wr;
  logic [SegIdxBits-1:0] raddr;
  logic [15:0] rstart;
  logic [16:0] rlen;
  logic tag_we;
  logic [TagBits-1:0] tag_waddr, tag_raddr;
  logic [16:0] tag_rdata;

  bffa_seg_table u_seg (.clk, .wr, .raddr, .rstart, .rlen);
  bffa_tag_store u_tag (.clk, .we(tag_we), .waddr(tag_waddr), .wdata(real_sz),
                        .raddr(tag_raddr), .rdata(tag_rdata));

  logic [17:0] hdr_req;
  logic [17:0] real_raw;
  logic [16:0] cfg_clamp;
  logic [SegCntBits-1:0] cnt_lim;
  logic [17:0] end_prev;
  logic [17:0] end_cur;
  logic jp, jn;

  assign hdr_req  = 18'(HdrSz) + 18'(s_axis_tdata[16:1]) + AlignMsk;
  assign real_raw = hdr_req & ~AlignMsk;
  assign cfg_clamp = (cfg_wdata < PoolMin) ? PoolMin :
                     (cfg_wdata > PoolMax) ? PoolMax : cfg_wdata;
  assign end_prev = {2'b0, prev_start} + {1'b0, prev_len};
  assign end_cur  = {1'b0, cur} + {1'b0, size};
  assign jp = has_prev && end_prev == {1'b0, cur};
  assign jn = has_nxt && end_cur == {2'b0, nxt_start};
  assign cnt_lim = (seg_count > SegCntBits'(MaxFreeSegs)) ? SegCntBits'(MaxFreeSegs)
                                                          : seg_count;

  assign s_axis_tready = (state == S_IDLE) && !cfg_we;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {3'b0, free_total, freed, blk_off, status};
  assign tag_waddr = TagBits'(pick_start >> AlignShift);
  // tag read starts while the item is being accepted
  assign tag_raddr = (state == S_IDLE) ?
                     TagBits'((17'(s_axis_tdata[32:17]) - HdrSz) >> AlignShift) :
                     TagBits'(cur >> AlignShift);
  assign tag_we    = (state == S_DECIDE) && !mode && found && free_total >= real_sz;

  always_comb begin
    state_next = state;
    raddr = idx[SegIdxBits-1:0];
    wr = '0;
    case (state)
      S_IDLE: begin
        if (cfg_we) state_next = S_REBUILD;
        else if (s_axis_tvalid) state_next = S_TAGRD;
      end
      S_REBUILD: begin
        wr.we = 1'b1; wr.waddr = '0; wr.wstart = FirstSt[15:0];
        wr.wlen = pool - NeedMin;
        state_next = S_IDLE;
      end
      S_TAGRD: state_next = S_SCAN;
      S_SCAN: begin
        if (!mode && exact) state_next = S_DECIDE;
        else if (mode && pos_done) state_next = S_DECIDE;
        else if (idx >= (SegIdxBits+1)'(cnt_lim) && !rd_ok) state_next = S_DECIDE;
      end
      S_DECIDE: state_next = S_WRITE;
      S_SHIFT_DN: begin
        // remove: entry sh <- entry sh+1, read one ahead
        raddr = SegIdxBits'(sh + 1'b1);
        if (sh_have) begin
          wr.we = 1'b1; wr.waddr = SegIdxBits'(sh - 1'b1);
          wr.wstart = rstart; wr.wlen = rlen;
        end
        if ((SegIdxBits+1)'(sh) >= (SegIdxBits+1)'(cnt_lim)) state_next = S_OUT;
      end
      S_SHIFT_UP: begin
        // insert: move entries up from the top down
        raddr = SegIdxBits'(sh - 2'd2);
        if (sh_have) begin
          wr.we = 1'b1; wr.waddr = SegIdxBits'(sh); wr.wstart = rstart; wr.wlen = rlen;
        end
        if (sh <= pos) begin
          wr.we = 1'b1; wr.waddr = SegIdxBits'(pos); wr.wstart = cur[15:0]; wr.wlen = size;
          state_next = S_OUT;
        end
      end
      S_WRITE: begin
        state_next = S_OUT;
        if (status == ST_OK) begin
          if (!mode) begin
            if (pick_len == real_sz) state_next = S_SHIFT_DN;
            else begin
              wr.we = 1'b1; wr.waddr = pick;
              wr.wstart = pick_start + real_sz[15:0]; wr.wlen = pick_len - real_sz;
            end
          end else if (jp && jn) begin
            wr.we = 1'b1; wr.waddr = SegIdxBits'(pos - 1'b1); wr.wstart = prev_start;
            wr.wlen = sat_add(sat_add(prev_len, size), nxt_len);
            state_next = S_SHIFT_DN;
          end else if (jp) begin
            wr.we = 1'b1; wr.waddr = SegIdxBits'(pos - 1'b1); wr.wstart = prev_start;
            wr.wlen = sat_add(prev_len, size);
          end else if (jn) begin
            wr.we = 1'b1; wr.waddr = SegIdxBits'(pos); wr.wstart = cur[15:0];
            wr.wlen = sat_add(nxt_len, size);
          end else begin
            state_next = S_SHIFT_UP;
          end
        end
      end
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_REBUILD;
      pool <= PoolMax;
    end else begin
      state <= state_next;
      if (state == S_IDLE && cfg_we) pool <= cfg_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_total <= '0;
      seg_count  <= '0;
    end else begin
      case (state)
        S_REBUILD: begin
          if (pool < NeedMin) begin
            free_total <= '0; seg_count <= '0;
          end else begin
            free_total <= pool - NeedMin; seg_count <= SegCntBits'(1);
          end
        end
        S_IDLE: begin
          if (!cfg_we && s_axis_tvalid) begin
            mode <= s_axis_tdata[0];
            poff <= s_axis_tdata[32:17];
            real_sz <= real_raw[17] ? Sat17 : real_raw[16:0];
            cur <= 17'(s_axis_tdata[32:17]) - HdrSz;
            idx <= '0; rd_ok <= 1'b0; found <= 1'b0; exact <= 1'b0;
            best <= Sat17; pick <= '0;
            pos <= '0; pos_done <= 1'b0; has_prev <= 1'b0; has_nxt <= 1'b0;
            status <= ST_OK; blk_off <= '0; freed <= '0;
          end
        end
        S_TAGRD: begin
          size <= tag_rdata;
          rd_ok <= (cnt_lim != '0);
          if (cnt_lim == '0) idx <= '0;
          else idx <= idx + 1'b1;
        end
        S_SCAN: begin
          if (idx < (SegIdxBits+1)'(cnt_lim)) begin
            idx <= idx + 1'b1;
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
          end
          // the first exact fit ends the search
          if (rd_ok && !exact) begin
            if (!mode) begin
              if (rlen == real_sz) begin
                exact <= 1'b1; found <= 1'b1; pick <= SegIdxBits'(idx - 1'b1);
                pick_start <= rstart; pick_len <= rlen;
              end else if ({1'b0, rlen} > {1'b0, real_sz} + LinkSz && rlen < best) begin
                best <= rlen; found <= 1'b1; pick <= SegIdxBits'(idx - 1'b1);
                pick_start <= rstart; pick_len <= rlen;
              end
            end else if (!pos_done) begin
              if ({1'b0, rstart} < cur) begin
                pos <= pos + 1'b1; has_prev <= 1'b1;
                prev_start <= rstart; prev_len <= rlen;
              end else begin
                pos_done <= 1'b1; has_nxt <= 1'b1;
                nxt_start <= rstart; nxt_len <= rlen;
              end
            end
          end
          if (mode && idx >= (SegIdxBits+1)'(cnt_lim) && !rd_ok) pos_done <= 1'b1;
        end
        S_DECIDE: begin
          if (!mode) begin
            if (free_total < real_sz) status <= ST_NO_TOTAL;
            else if (!found) status <= ST_NO_FIT;
            else begin
              blk_off <= pick_start + HdrSz[15:0];
              free_total <= free_total - real_sz;
            end
          end else begin
            if (pool < NeedMin || poff < HdrSz[15:0] || cur < FirstSt ||
                cur >= pool || (cur & AlignMsk[16:0]) != '0) begin
              status <= ST_BAD_ADDR;
            end else if (!jp && !jn && seg_count >= SegCntBits'(MaxFreeSegs)) begin
              status <= ST_FULL;
            end else begin
              free_total <= sat_add(free_total, size);
              freed <= size;
            end
          end
        end
        S_WRITE: begin
          sh_have <= 1'b0;
          if (status == ST_OK) begin
            if (!mode && pick_len == real_sz) begin
              sh <= (SegIdxBits+1)'(pick); seg_count <= seg_count - 1'b1;
            end else if (mode && jp && jn) begin
              sh <= pos; seg_count <= seg_count - 1'b1;
            end else if (mode && !jp && !jn) begin
              sh <= (SegIdxBits+1)'(seg_count) + 1'b1; seg_count <= seg_count + 1'b1;
            end
          end
        end
        S_SHIFT_DN: begin
          sh <= sh + 1'b1; sh_have <= 1'b1;
        end
        S_SHIFT_UP: begin
          sh <= sh - 1'b1; sh_have <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

/* bench/best_fit_free_list_allocator_tb.sv */
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_tb
// drives allocate and free items through the stream ports, keeps a local
// segment table and tag store, and compares every result field by field
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_tb;
  import bffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {MODE_ALLOC = 1'b0, MODE_FREE = 1'b1} mode_t;

  typedef struct packed {
    logic [15:0] payload_offset;
    logic [15:0] request_bytes;
    logic        mode;
  } req_item_t;

  typedef struct packed {
    logic [16:0] avail_bytes;
    logic [16:0] freed_bytes;
    logic [15:0] block_offset;
    status_t     status;
  } rsp_item_t;

  localparam int CycleLimit = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  best_fit_free_list_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator image kept by the bench
  logic [16:0] pool_size;
  logic [16:0] run_start [MaxFreeSegs];
  logic [16:0] run_len   [MaxFreeSegs];
  int          run_count;
  logic [16:0] bytes_free;
  logic [16:0] size_tag  [TagDepth];
  logic [15:0] live_blocks [$];

  req_item_t   pending_items [$];
  rsp_item_t   expected_rsp [$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          hold_off = 0;
  bit          quiet_gaps = 0;
  logic        s_axis_tready_q = 1'b0;
  logic        m_axis_tvalid_q = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_gaps || r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic logic [17:0] align_up(input logic [17:0] x);
    return 18'(((x + AlignBytes - 1) / AlignBytes) * AlignBytes);
  endfunction

  function automatic logic [16:0] add_sat(input logic [16:0] a, input logic [16:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 131071) ? 17'h1FFFF : 17'(s);
  endfunction

  task automatic set_pool(input logic [16:0] v);
    int need;
    need = FirstStart + LinkBytes;
    if (v < 64) v = 17'd64;
    if (v > PoolLimit) v = 17'(PoolLimit);
    pool_size = v;
    foreach (size_tag[i]) size_tag[i] = '0;
    foreach (run_start[i]) begin
      run_start[i] = '0;
      run_len[i] = '0;
    end
    live_blocks.delete();
    if (int'(v) < need) begin
      run_count = 0;
      bytes_free = '0;
    end else begin
      bytes_free = 17'(int'(v) - need);
      run_start[0] = 17'(FirstStart);
      run_len[0] = bytes_free;
      run_count = 1;
    end
  endtask

  function automatic rsp_item_t alloc_predict(input logic [15:0] req);
    rsp_item_t r;
    int real_sz, pick, best, found;
    r = '0;
    r.status = ST_OK;
    real_sz = int'(align_up(18'(HdrSize) + 18'(req)));
    pick = 0;
    best = 32'h7FFFFFFF;
    found = 0;
    if (int'(bytes_free) < real_sz) begin
      r.status = ST_NO_TOTAL;
    end else begin
      for (int i = 0; i < run_count; i++) begin
        if (int'(run_len[i]) == real_sz) begin
          pick = i;
          found = 1;
          break;
        end
        if (int'(run_len[i]) > real_sz + LinkBytes && int'(run_len[i]) < best) begin
          best = int'(run_len[i]);
          pick = i;
          found = 1;
        end
      end
      if (!found) begin
        r.status = ST_NO_FIT;
      end else begin
        r.block_offset = 16'(int'(run_start[pick]) + HdrSize);
        live_blocks.push_back(r.block_offset);
        size_tag[(int'(run_start[pick]) / AlignBytes) % TagDepth] = 17'(real_sz);
        bytes_free = 17'(int'(bytes_free) - real_sz);
        if (int'(run_len[pick]) == real_sz) begin
          for (int i = pick; i < run_count - 1; i++) begin
            run_start[i] = run_start[i+1];
            run_len[i] = run_len[i+1];
          end
          run_count--;
        end else begin
          run_start[pick] = 17'(int'(run_start[pick]) + real_sz);
          run_len[pick] = 17'(int'(run_len[pick]) - real_sz);
        end
      end
    end
    r.avail_bytes = bytes_free;
    return r;
  endfunction

  function automatic rsp_item_t free_predict(input logic [15:0] p);
    rsp_item_t r;
    int cur, sz, pos;
    bit jp, jn;
    r = '0;
    r.status = ST_OK;
    cur = int'(p) - HdrSize;
    if ((run_count == 0 && bytes_free == 0 && int'(pool_size) < FirstStart + LinkBytes)
        || int'(p) < HdrSize || cur < FirstStart || cur >= int'(pool_size)
        || (cur % AlignBytes) != 0) begin
      r.status = ST_BAD_ADDR;
    end else begin
      sz = int'(size_tag[(cur / AlignBytes) % TagDepth]);
      pos = 0;
      while (pos < run_count && int'(run_start[pos]) < cur) pos++;
      jp = pos > 0 && int'(run_start[pos-1]) + int'(run_len[pos-1]) == cur;
      jn = pos < run_count && cur + sz == int'(run_start[pos]);
      if (!jp && !jn && run_count >= MaxFreeSegs) begin
        r.status = ST_FULL;
      end else begin
        foreach (live_blocks[i]) if (live_blocks[i] == p) begin
          live_blocks.delete(i);
          break;
        end
        bytes_free = add_sat(bytes_free, 17'(sz));
        r.freed_bytes = 17'(sz);
        if (jp && jn) begin
          run_len[pos-1] = add_sat(add_sat(run_len[pos-1], 17'(sz)), run_len[pos]);
          for (int i = pos; i < run_count - 1; i++) begin
            run_start[i] = run_start[i+1];
            run_len[i] = run_len[i+1];
          end
          run_count--;
        end else if (jp) begin
          run_len[pos-1] = add_sat(run_len[pos-1], 17'(sz));
        end else if (jn) begin
          run_start[pos] = 17'(cur);
          run_len[pos] = add_sat(run_len[pos], 17'(sz));
        end else begin
          for (int i = run_count; i > pos; i--) begin
            run_start[i] = run_start[i-1];
            run_len[i] = run_len[i-1];
          end
          run_start[pos] = 17'(cur);
          run_len[pos] = 17'(sz);
          run_count++;
        end
      end
    end
    r.avail_bytes = bytes_free;
    return r;
  endfunction

  // driver: next item leaves the queue only after the previous one is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        if (gap_left == 0 && pending_items.size() > 0 && !hold_off) begin
          s_axis_tdata <= {7'd0, pending_items.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
        gap_left = gap_len();
      end else if (!s_axis_tvalid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 && !hold_off) begin
          s_axis_tdata <= {7'd0, pending_items.pop_front()};
          s_axis_tvalid <= 1'b1;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid_q && m_axis_tready) stall_left = gap_len();
      end
    end
  end

  // input acceptance and result checking at the rising edge
  always @(posedge clk) begin
    rsp_item_t got, exp_r;
    req_item_t it;
    cycle_count++;
    s_axis_tready_q <= 1'b0;
    m_axis_tvalid_q <= 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tready_q <= 1'b1;
        it = req_item_t'(s_axis_tdata[32:0]);
        if (it.mode == MODE_ALLOC) expected_rsp.push_back(alloc_predict(it.request_bytes));
        else expected_rsp.push_back(free_predict(it.payload_offset));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid_q <= 1'b1;
        got = rsp_item_t'(m_axis_tdata[52:0]);
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result item %p", $realtime, got);
          err_count++;
        end else begin
          exp_r = expected_rsp.pop_front();
          if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
            err_count++;
          end
          if (got.block_offset !== exp_r.block_offset) begin
            $display("%0t: block_offset exp %0d got %0d", $realtime,
                     exp_r.block_offset, got.block_offset);
            err_count++;
          end
          if (got.freed_bytes !== exp_r.freed_bytes) begin
            $display("%0t: freed_bytes exp %0d got %0d", $realtime,
                     exp_r.freed_bytes, got.freed_bytes);
            err_count++;
          end
          if (got.avail_bytes !== exp_r.avail_bytes) begin
            $display("%0t: avail_bytes exp %0d got %0d", $realtime,
                     exp_r.avail_bytes, got.avail_bytes);
            err_count++;
          end
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_alloc(input logic [15:0] req);
    pending_items.push_back('{payload_offset: 16'($urandom), request_bytes: req,
                              mode: MODE_ALLOC});
  endtask

  task automatic push_free(input logic [15:0] off);
    pending_items.push_back('{payload_offset: off, request_bytes: 16'($urandom),
                              mode: MODE_FREE});
  endtask

  // the predictor runs at acceptance, so wait for the bench to go quiet
  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_rsp.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // frees pick from the live list, so each item is predicted before the next is chosen
  task automatic drain_light();
    while (pending_items.size() > 0) @(posedge clk);
    while (s_axis_tvalid) @(posedge clk);
  endtask

  task automatic write_pool(input logic [16:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_pool(v);
  endtask

  // free a block known to be live, or a bad address now and then
  task automatic random_free();
    int r;
    logic [15:0] off;
    r = $urandom_range(0, 99);
    if (live_blocks.size() > 0 && r < 85) begin
      off = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      push_free(off);
    end else begin
      // out of pool, unaligned or below the first segment
      case ($urandom_range(0, 3))
        0: off = 16'($urandom_range(0, HdrSize + FirstStart - 1));
        1: off = 16'(int'(pool_size) + HdrSize + $urandom_range(0, 64) * AlignBytes);
        2: off = 16'($urandom_range(FirstStart, 65000) | 1);
        default: off = 16'hFFFF;
      endcase
      // never hit a never-written tag: keep only provably bad ones
      if (int'(off) >= HdrSize + FirstStart && int'(off) - HdrSize < int'(pool_size)
          && ((int'(off) - HdrSize) % AlignBytes) == 0) off = 16'h0001;
      push_free(off);
    end
  endtask

  // the live list tracks acceptance, so random items are issued one at a time
  task automatic random_phase(input int n, input int big_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0 || live_blocks.size() == 0) begin
        if ($urandom_range(0, 99) < big_pct) push_alloc(16'($urandom));
        else push_alloc(16'($urandom_range(0, 300)));
        drain_light();
      end else begin
        random_free();
        drain_light();
      end
    end
  endtask

  initial begin
    set_pool(17'd65536);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, exact fit, split, merges, bad addresses
    push_alloc(16'd0);
    push_alloc(16'hFFFF);
    push_alloc(16'd1);
    push_alloc(16'd100);
    push_alloc(16'd24);
    drain_light();
    push_free(16'h0000);
    push_free(16'hFFFF);
    push_free(16'd25);
    push_free(16'd32);
    drain_light();
    push_free(16'd48);
    push_free(16'd32 + 16);
    drain();

    write_pool(17'd64);
    push_alloc(16'd8);
    push_alloc(16'd16);
    push_alloc(16'd0);
    drain_light();
    if (live_blocks.size() > 0) push_free(live_blocks[0]);
    drain();

    write_pool(17'd0);
    push_alloc(16'd0);
    push_free(16'd24);
    drain();

    write_pool(17'h1FFFF);
    quiet_gaps = 1;
    random_phase(40, 5);
    quiet_gaps = 0;
    drain();

    // fill the table with many small holes
    write_pool(17'd4096);
    for (int k = 0; k < 90; k++) begin
      push_alloc(16'd8);
      drain_light();
    end
    for (int k = 0; k < live_blocks.size(); k += 2) begin
      push_free(live_blocks[k]);
      drain_light();
    end
    drain();

    // sender holds off until everything has come back
    hold_off = 1;
    repeat (50) @(posedge clk);
    hold_off = 0;

    write_pool(17'd65536);
    random_phase(150, 10);
    drain();
    write_pool(17'(300 + $urandom_range(0, 2000)));
    random_phase(120, 3);
    drain();
    write_pool(17'd65535);
    random_phase(120, 8);
    drain();

    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
